// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PCSE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a condition in the same cycle as its trigger.
`define PCSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger.
`define PCSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/pcse_pkg.sv
`timescale 1ns / 1ps

package pcse_pkg;

  // Bus geometry
  localparam int SLOTS_PER_BUS      = 32;
  localparam int FUNCTIONS_PER_SLOT = 8;

  // Result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_DEVICE = 2'd1,
    KIND_CAP    = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  // Register indexes
  localparam logic [1:0] CFG_LAST_BUS  = 2'd0;
  localparam logic [1:0] CFG_HOP_LIMIT = 2'd1;
  localparam logic [1:0] CFG_ID_LIMIT  = 2'd2;

  // Register reset values
  localparam logic [7:0] LAST_BUS_RST  = 8'd255;
  localparam logic [5:0] HOP_LIMIT_RST = 6'd48;
  localparam logic [7:0] ID_LIMIT_RST  = 8'd20;

  // Config space offsets and codes
  localparam logic [7:0]  OFF_ID       = 8'h00;
  localparam logic [7:0]  OFF_STATUS   = 8'h04;
  localparam logic [7:0]  OFF_HDR      = 8'h0C;
  localparam logic [7:0]  OFF_BAR0     = 8'h10;
  localparam logic [7:0]  OFF_IRQ      = 8'h3C;
  localparam logic [7:0]  CAP_PTR_STD  = 8'h34;
  localparam logic [7:0]  CAP_PTR_CB   = 8'h14;
  localparam logic [7:0]  HDR_CARDBUS  = 8'h02;
  localparam logic [7:0]  CAP_PTR_MIN  = 8'h40;
  localparam logic [7:0]  CAP_ID_END   = 8'hFF;
  localparam logic [15:0] VENDOR_NONE  = 16'hFFFF;
  localparam logic [3:0]  BAR_LAST     = 4'd5;
  localparam int          STATUS_CAP_BIT = 20;
  localparam int          HDR_MULTI_BIT  = 7;

  typedef struct packed {
    logic [7:0] last_bus;
    logic [5:0] cap_hop_limit;
    logic [7:0] cap_id_limit;
  } cfg_t;

  typedef struct packed {
    kind_t        out_kind;
    logic [31:0]  cfg_address;
    logic [15:0]  location;
    logic [15:0]  vendor_code;
    logic [15:0]  device_code;
    logic [31:0]  io_base;
    logic [63:0]  mem_base;
    logic [7:0]   irq_line;
    logic [7:0]   cap_id;
    logic [7:0]   cap_offset;
    logic         last;
  } res_t;

  // Results of one step, in order
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

// File: src/pcse_if.sv
`timescale 1ns / 1ps

interface pcse_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] read_data;

  modport source (output valid, output req_type, output read_data, input ready);
  modport sink   (input valid, input req_type, input read_data, output ready);
endinterface

interface pcse_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [31:0] cfg_address;
  logic [15:0] location;
  logic [15:0] vendor_code;
  logic [15:0] device_code;
  logic [31:0] io_base;
  logic [63:0] mem_base;
  logic [7:0]  irq_line;
  logic [7:0]  cap_id;
  logic [7:0]  cap_offset;
  logic        last;

  modport source (
    output valid, output out_kind, output cfg_address, output location,
    output vendor_code, output device_code, output io_base, output mem_base,
    output irq_line, output cap_id, output cap_offset, output last,
    input ready
  );
  modport sink (
    input valid, input out_kind, input cfg_address, input location,
    input vendor_code, input device_code, input io_base, input mem_base,
    input irq_line, input cap_id, input cap_offset, input last,
    output ready
  );
endinterface

// File: src/pcse_seq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcse_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             item_type,
  input  logic [31:0]      item_data,
  input  pcse_pkg::cfg_t   cfg,
  output pcse_pkg::push_t  push
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ID, PH_HDR, PH_BAR, PH_BARHI, PH_IRQ, PH_STATUS, PH_CAPPTR, PH_CAPID
  } phase_t;

  localparam logic [3:0] FN_LIMIT   = 4'(pcse_pkg::FUNCTIONS_PER_SLOT);
  localparam logic [5:0] SLOT_LIMIT = 6'(pcse_pkg::SLOTS_PER_BUS);

  phase_t      phase, phase_next;
  logic [7:0]  bus_index, bus_index_next;
  logic [4:0]  slot_index, slot_index_next;
  logic [2:0]  function_index, function_index_next;
  logic [31:0] id_word, id_word_next;
  logic [7:0]  header_byte, header_byte_next;
  logic [3:0]  bar_index, bar_index_next;
  logic [31:0] io_value, io_value_next;
  logic        io_valid, io_valid_next;
  logic [63:0] mem_value, mem_value_next;
  logic        mem_valid, mem_valid_next;
  logic [7:0]  irq_byte, irq_byte_next;
  logic [7:0]  cap_pointer, cap_pointer_next;
  logic [5:0]  hop_count, hop_count_next;

  logic             issue;
  logic [7:0]       offset;
  logic             rec_valid;
  pcse_pkg::res_t   rec;
  pcse_pkg::res_t   read_req;
  logic             done;
  logic             adv;
  logic             adv_slot;
  logic             begin_fn;
  logic             bar_go;
  logic [3:0]       bar_sel;
  logic             try_ptr;
  logic [7:0]       ptr_byte;

  function automatic logic [7:0] bar_offset(input logic [3:0] b);
    bar_offset = pcse_pkg::OFF_BAR0 + {2'b00, b, 2'b00};
  endfunction

  // Work out one step of the scan
  always_comb begin
    phase_next          = phase;
    bus_index_next      = bus_index;
    slot_index_next     = slot_index;
    function_index_next = function_index;
    id_word_next        = id_word;
    header_byte_next    = header_byte;
    bar_index_next      = bar_index;
    io_value_next       = io_value;
    io_valid_next       = io_valid;
    mem_value_next      = mem_value;
    mem_valid_next      = mem_valid;
    irq_byte_next       = irq_byte;
    cap_pointer_next    = cap_pointer;
    hop_count_next      = hop_count;
    issue     = 1'b0;
    offset    = '0;
    rec_valid = 1'b0;
    rec       = '0;
    done      = 1'b0;
    adv       = 1'b0;
    adv_slot  = 1'b0;
    begin_fn  = 1'b0;
    bar_go    = 1'b0;
    bar_sel   = bar_index;
    try_ptr   = 1'b0;
    ptr_byte  = '0;

    if (step) begin
      if (item_type == pcse_pkg::REQ_START) begin
        bus_index_next      = '0;
        slot_index_next     = '0;
        function_index_next = '0;
        id_word_next        = '0;
        header_byte_next    = '0;
        begin_fn            = 1'b1;
      end else begin
        case (phase)
          PH_ID: begin
            if (item_data[15:0] == pcse_pkg::VENDOR_NONE) begin
              adv      = 1'b1;
              adv_slot = 1'b1;
            end else begin
              id_word_next = item_data;
              phase_next   = PH_HDR;
              issue        = 1'b1;
              offset       = pcse_pkg::OFF_HDR;
            end
          end
          PH_HDR: begin
            header_byte_next = item_data[23:16];
            bar_index_next   = '0;
            bar_sel          = '0;
            bar_go           = 1'b1;
          end
          PH_BAR: begin
            if (item_data[0]) begin
              if (!io_valid) begin
                io_value_next = {item_data[31:2], 2'b00};
                io_valid_next = 1'b1;
              end
              bar_index_next = bar_index + 4'd1;
              bar_sel        = bar_index + 4'd1;
              bar_go         = 1'b1;
            end else if (!mem_valid && item_data[2]) begin
              mem_value_next = {32'd0, item_data[31:4], 4'd0};
              phase_next     = PH_BARHI;
              issue          = 1'b1;
              offset         = bar_offset(bar_index + 4'd1);
            end else begin
              if (!mem_valid) begin
                mem_value_next = {32'd0, item_data[31:4], 4'd0};
                mem_valid_next = 1'b1;
              end
              bar_index_next = bar_index + 4'd1;
              bar_sel        = bar_index + 4'd1;
              bar_go         = 1'b1;
            end
          end
          PH_BARHI: begin
            mem_value_next = {item_data, mem_value[31:0]};
            mem_valid_next = 1'b1;
            bar_index_next = bar_index + 4'd2;
            bar_sel        = bar_index + 4'd2;
            bar_go         = 1'b1;
          end
          PH_IRQ: begin
            irq_byte_next   = item_data[7:0];
            rec_valid       = 1'b1;
            rec.out_kind    = pcse_pkg::KIND_DEVICE;
            rec.location    = {bus_index, slot_index, function_index};
            rec.vendor_code = id_word[15:0];
            rec.device_code = id_word[31:16];
            rec.io_base     = io_valid ? io_value : 32'd0;
            rec.mem_base    = mem_valid ? mem_value : 64'd0;
            rec.irq_line    = item_data[7:0];
            phase_next      = PH_STATUS;
            issue           = 1'b1;
            offset          = pcse_pkg::OFF_STATUS;
          end
          PH_STATUS: begin
            if (item_data[pcse_pkg::STATUS_CAP_BIT]) begin
              cap_pointer_next = (header_byte == pcse_pkg::HDR_CARDBUS) ?
                                 pcse_pkg::CAP_PTR_CB : pcse_pkg::CAP_PTR_STD;
              hop_count_next   = '0;
              try_ptr          = 1'b1;
            end else begin
              adv      = 1'b1;
              adv_slot = !header_byte[pcse_pkg::HDR_MULTI_BIT];
            end
          end
          PH_CAPPTR: begin
            case (cap_pointer[1:0])
              2'd0:    ptr_byte = item_data[7:0];
              2'd1:    ptr_byte = item_data[15:8];
              2'd2:    ptr_byte = item_data[23:16];
              default: ptr_byte = item_data[31:24];
            endcase
            if (ptr_byte < pcse_pkg::CAP_PTR_MIN) begin
              adv      = 1'b1;
              adv_slot = !header_byte[pcse_pkg::HDR_MULTI_BIT];
            end else begin
              cap_pointer_next = {ptr_byte[7:2], 2'b00};
              phase_next       = PH_CAPID;
              issue            = 1'b1;
              offset           = {ptr_byte[7:2], 2'b00};
            end
          end
          PH_CAPID: begin
            if (item_data[7:0] == pcse_pkg::CAP_ID_END) begin
              adv      = 1'b1;
              adv_slot = !header_byte[pcse_pkg::HDR_MULTI_BIT];
            end else begin
              if (item_data[7:0] <= cfg.cap_id_limit) begin
                rec_valid      = 1'b1;
                rec.out_kind   = pcse_pkg::KIND_CAP;
                rec.location   = {bus_index, slot_index, function_index};
                rec.cap_id     = item_data[7:0];
                rec.cap_offset = {cap_pointer[7:2], 2'b00};
              end
              cap_pointer_next = cap_pointer + 8'd1;
              hop_count_next   = hop_count + 6'd1;
              try_ptr          = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // Pick the next BAR or move on to the interrupt line
    if (bar_go) begin
      issue = 1'b1;
      if (bar_sel > pcse_pkg::BAR_LAST) begin
        phase_next = PH_IRQ;
        offset     = pcse_pkg::OFF_IRQ;
      end else begin
        phase_next = PH_BAR;
        offset     = bar_offset(bar_sel);
      end
    end

    // Follow the capability list unless the hop limit is reached
    if (try_ptr) begin
      if (hop_count_next >= cfg.cap_hop_limit) begin
        adv      = 1'b1;
        adv_slot = !header_byte[pcse_pkg::HDR_MULTI_BIT];
      end else begin
        phase_next = PH_CAPPTR;
        issue      = 1'b1;
        offset     = cap_pointer_next;
      end
    end

    // Advance to the next function, slot or bus
    if (adv) begin
      if (!adv_slot && (({1'b0, function_index} + 4'd1) < FN_LIMIT)) begin
        function_index_next = function_index + 3'd1;
        begin_fn            = 1'b1;
      end else begin
        function_index_next = '0;
        if (({1'b0, slot_index} + 6'd1) < SLOT_LIMIT) begin
          slot_index_next = slot_index + 5'd1;
          begin_fn        = 1'b1;
        end else begin
          slot_index_next = '0;
          if (bus_index >= cfg.last_bus) begin
            done           = 1'b1;
            phase_next     = PH_IDLE;
            bus_index_next = '0;
          end else begin
            bus_index_next = bus_index + 8'd1;
            begin_fn       = 1'b1;
          end
        end
      end
    end

    // Open a fresh function with its ID read
    if (begin_fn) begin
      io_value_next    = '0;
      io_valid_next    = 1'b0;
      mem_value_next   = '0;
      mem_valid_next   = 1'b0;
      irq_byte_next    = '0;
      hop_count_next   = '0;
      bar_index_next   = '0;
      cap_pointer_next = '0;
      phase_next       = PH_ID;
      issue            = 1'b1;
      offset           = pcse_pkg::OFF_ID;
    end
  end

  // Build the read request and order the results
  always_comb begin
    read_req             = '0;
    read_req.out_kind    = pcse_pkg::KIND_READ;
    read_req.cfg_address = {1'b1, 7'd0, bus_index_next, slot_index_next,
                            function_index_next, offset[7:2], 2'b00};
    read_req.location    = {bus_index_next, slot_index_next, function_index_next};
    push = '0;
    if (done) begin
      if (rec_valid) begin
        push.count           = 2'd2;
        push.first           = rec;
        push.second.out_kind = pcse_pkg::KIND_DONE;
        push.second.last     = 1'b1;
      end else begin
        push.count             = 2'd1;
        push.first.out_kind    = pcse_pkg::KIND_DONE;
        push.first.last        = 1'b1;
      end
    end else if (rec_valid) begin
      push.count       = 2'd2;
      push.first       = rec;
      push.second      = read_req;
      push.second.last = 1'b1;
    end else if (issue) begin
      push.count      = 2'd1;
      push.first      = read_req;
      push.first.last = 1'b1;
    end
  end

  // Hold the walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bus_index      <= '0;
      slot_index     <= '0;
      function_index <= '0;
      io_valid       <= 1'b0;
      mem_valid      <= 1'b0;
    end else begin
      phase          <= phase_next;
      bus_index      <= bus_index_next;
      slot_index     <= slot_index_next;
      function_index <= function_index_next;
      io_valid       <= io_valid_next;
      mem_valid      <= mem_valid_next;
    end
    id_word     <= id_word_next;
    header_byte <= header_byte_next;
    bar_index   <= bar_index_next;
    io_value    <= io_value_next;
    mem_value   <= mem_value_next;
    irq_byte    <= irq_byte_next;
    cap_pointer <= cap_pointer_next;
    hop_count   <= hop_count_next;
  end

  // A live scan or a start always answers with at least one result
  `PCSE_ASSERT_SAME(a_step_answers, step && (item_type == pcse_pkg::REQ_START || phase != PH_IDLE), push.count != 2'd0, "scan step produced no result")
  // The done record leaves the engine idle
  `PCSE_ASSERT_NEXT(a_done_idles, step && push.count == 2'd1 && push.first.out_kind == pcse_pkg::KIND_DONE, phase == PH_IDLE, "engine not idle after done record")
  // An upper BAR word is only fetched before a memory BAR is recorded
  `PCSE_ASSERT_ALWAYS(a_barhi_first, phase != PH_BARHI || !mem_valid, "upper BAR word read after memory BAR found")

endmodule

// File: src/pcse_out_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcse_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  pcse_pkg::push_t   push,
  output logic              room,
  pcse_out_if.source        rsp
);

  pcse_pkg::res_t                 queue [pcse_pkg::OUT_DEPTH];
  logic [pcse_pkg::OUT_PTR_W-1:0] wr_ptr;
  logic [pcse_pkg::OUT_PTR_W-1:0] rd_ptr;
  logic [pcse_pkg::OUT_CNT_W-1:0] count;
  logic [pcse_pkg::OUT_CNT_W-1:0] count_next;
  logic                           pop;
  pcse_pkg::res_t                 head;

  // Room for a full step of results
  assign room = count <= pcse_pkg::OUT_CNT_W'(pcse_pkg::OUT_DEPTH - 2);
  assign pop  = rsp.valid && rsp.ready;
  assign head = queue[rd_ptr];

  assign count_next = count + pcse_pkg::OUT_CNT_W'(push.count)
                      - pcse_pkg::OUT_CNT_W'(pop);

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      queue[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      queue[wr_ptr + pcse_pkg::OUT_PTR_W'(1)] <= push.second;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + pcse_pkg::OUT_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + pcse_pkg::OUT_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // Present the oldest result
  assign rsp.valid       = count != '0;
  assign rsp.out_kind    = head.out_kind;
  assign rsp.cfg_address = head.cfg_address;
  assign rsp.location    = head.location;
  assign rsp.vendor_code = head.vendor_code;
  assign rsp.device_code = head.device_code;
  assign rsp.io_base     = head.io_base;
  assign rsp.mem_base    = head.mem_base;
  assign rsp.irq_line    = head.irq_line;
  assign rsp.cap_id      = head.cap_id;
  assign rsp.cap_offset  = head.cap_offset;
  assign rsp.last        = head.last;

  `PCSE_ASSERT_ALWAYS(a_count_bound, count <= pcse_pkg::OUT_CNT_W'(pcse_pkg::OUT_DEPTH), "result queue overfilled")
  `PCSE_ASSERT_SAME(a_push_fits, push.count != 2'd0, (32'(count) + 32'(push.count)) <= pcse_pkg::OUT_DEPTH, "push beyond queue space")
  `PCSE_ASSERT_NEXT(a_single_push, count == '0 && push.count == 2'd1, count == pcse_pkg::OUT_CNT_W'(1), "single push into empty queue lost")

endmodule

// File: src/pci_config_space_enumerator_core.sv
`timescale 1ns / 1ps

// Host-side PCI configuration mechanism one scan engine. A start transfer
// (req_type 0) restarts the walk at bus 0 and answers with the first config
// address; each data transfer (req_type 1) carries the dword read back for the
// last address and answers with the next read request, preceded by a device
// or capability record where one is due, or with a done record (after any
// capability record still due) once the last slot of bus last_bus is passed.
// Data while idle is dropped. The last flag marks the final result of each
// transfer. An input transfer is registered and then processed, so one is
// taken every cycle while the result queue (four entries, drained one result
// per cycle while rsp.ready is high) has space for two more; a transfer that
// yields two results thus holds the sustained rate at its output to one
// result per cycle. The user must write config registers only while no scan
// step is pending; the block itself does not enforce this.
module pci_config_space_enumerator_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  pcse_in_if.sink    req,
  pcse_out_if.source rsp
);

  pcse_pkg::cfg_t  cfg;
  pcse_pkg::push_t push;
  logic            room;
  logic            stage_valid;
  logic            stage_type;
  logic [31:0]     stage_data;
  logic            step;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.last_bus      <= pcse_pkg::LAST_BUS_RST;
      cfg.cap_hop_limit <= pcse_pkg::HOP_LIMIT_RST;
      cfg.cap_id_limit  <= pcse_pkg::ID_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pcse_pkg::CFG_LAST_BUS:  cfg.last_bus      <= cfg_wdata;
        pcse_pkg::CFG_HOP_LIMIT: cfg.cap_hop_limit <= cfg_wdata[5:0];
        pcse_pkg::CFG_ID_LIMIT:  cfg.cap_id_limit  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input register: drains whenever the queue can take a whole step
  assign step      = stage_valid && room;
  assign req.ready = !stage_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      stage_valid <= 1'b1;
    end else if (step) begin
      stage_valid <= 1'b0;
    end
    if (req.valid && req.ready) begin
      stage_type <= req.req_type;
      stage_data <= req.read_data;
    end
  end

  pcse_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item_type (stage_type),
    .item_data (stage_data),
    .cfg       (cfg),
    .push      (push)
  );

  pcse_out_fifo u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .rsp  (rsp)
  );

endmodule
